FILE: sv/lslm_pkg.sv
// ----------------------------------------------------------------------------
// lslm_pkg: shared types and constants of the level-marker strip framer
// Field widths, fixed strip words, register indexes and the classified
// request that travels from the front to the back.
// ----------------------------------------------------------------------------
package lslm_pkg;

	localparam int LEVEL_W   = 8;
	localparam int POS_W     = 8;
	localparam int WORD_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 8;

	// register indexes of the config port
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_BLUE  = 2'd2;

	localparam logic [CFG_W-1:0] RED_RESET   = 8'hFF;
	localparam logic [CFG_W-1:0] GREEN_RESET = 8'h00;
	localparam logic [CFG_W-1:0] BLUE_RESET  = 8'h00;

	// divide by three for 8-bit values: (x * 171) >> 9
	localparam int DIV3_PROD_W = 16;
	localparam logic [LEVEL_W-1:0] DIV3_MUL = 8'd171;
	localparam int DIV3_SHIFT = 9;
	localparam logic [POS_W-1:0] MARKER_OFFSET = 8'd8;

	localparam logic [WORD_W-1:0] WORD_START = 32'h0000_0000;
	localparam logic [WORD_W-1:0] WORD_END   = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0] WORD_GREEN = 32'hFF00_FF00;
	localparam logic [WORD_W-1:0] WORD_OFF   = 32'hE000_0000;
	localparam logic [7:0] HDR_FULL = 8'hFF;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [CFG_W-1:0] blue;
		logic [CFG_W-1:0] green;
		logic [CFG_W-1:0] red;
	} colour_t;

	typedef struct packed {
		logic [POS_W-1:0] marker;
		logic [POS_W-1:0] target;
		logic             hit;
	} task_t;

	// |a - b| <= k without wrap-around
	function automatic logic near(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b,
			input logic [POS_W-1:0] k);
		logic [POS_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d <= k;
	endfunction

endpackage

FILE: sv/lslm_if.sv
// ----------------------------------------------------------------------------
// lslm_if: request and frame channels
// Valid/ready channels; a request or word moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface lslm_req_if;
	logic                          valid;
	logic                          ready;
	logic [lslm_pkg::LEVEL_W-1:0] level;
	logic [lslm_pkg::POS_W-1:0]   target;

	modport source (output valid, output level, output target, input ready);
	modport sink   (input valid, input level, input target, output ready);
endinterface

interface lslm_frame_if;
	logic                         valid;
	logic                         ready;
	logic [lslm_pkg::WORD_W-1:0] frame_word;
	logic                         last;

	modport source (output valid, output frame_word, output last, input ready);
	modport sink   (input valid, input frame_word, input last, output ready);
endinterface

FILE: sv/lslm_front.sv
// ----------------------------------------------------------------------------
// lslm_front: request intake and classification
// Registers a request, derives the marker index and the target-hit flag.
// ----------------------------------------------------------------------------
module lslm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	lslm_req_if.sink              req,
	output logic                  push_valid,
	output lslm_pkg::task_t       push_data,
	input  logic                  push_ready
);

	logic                          valid_s1;
	logic [lslm_pkg::LEVEL_W-1:0] level_s1;
	logic [lslm_pkg::POS_W-1:0]   target_s1;
	logic [lslm_pkg::DIV3_PROD_W-1:0] prod;
	logic [lslm_pkg::POS_W-1:0]   quot;
	logic [lslm_pkg::POS_W-1:0]   marker;
	logic                          take;

	assign req.ready = !valid_s1 || push_ready;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			level_s1  <= req.level;
			target_s1 <= req.target;
		end
	end

	// level / 3 by reciprocal multiply, then minus 8 modulo 256
	assign prod   = lslm_pkg::DIV3_PROD_W'(level_s1) * lslm_pkg::DIV3_PROD_W'(lslm_pkg::DIV3_MUL);
	assign quot   = lslm_pkg::POS_W'(prod >> lslm_pkg::DIV3_SHIFT);
	assign marker = quot - lslm_pkg::MARKER_OFFSET;

	assign push_valid       = valid_s1;
	assign push_data.marker = marker;
	assign push_data.target = target_s1;
	assign push_data.hit    = lslm_pkg::near(marker, target_s1, 8'd1);

endmodule

FILE: sv/lslm_queue.sv
// ----------------------------------------------------------------------------
// lslm_queue: short queue of classified requests
// Two-entry first-in first-out store between front and back.
// ----------------------------------------------------------------------------
module lslm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  lslm_pkg::task_t push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output lslm_pkg::task_t pop_data,
	input  logic            pop_ready
);

	localparam int AW = $clog2(lslm_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(lslm_pkg::QUEUE_DEPTH + 1);

	lslm_pkg::task_t mem_q [lslm_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = count_q != CW'(lslm_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(lslm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(lslm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: sv/lslm_back.sv
// ----------------------------------------------------------------------------
// lslm_back: frame word sequencer
// Walks one frame per queued request, one word per cycle while the receiver is
// ready, into an output register: start word, one word per led, end word.
// ----------------------------------------------------------------------------
module lslm_back #(
	parameter int LED_COUNT = 60
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  lslm_pkg::task_t   pop_data,
	output logic              pop_ready,
	input  lslm_pkg::colour_t colour,
	lslm_frame_if.source      frame
);

	localparam int PW = $clog2(LED_COUNT + 2);
	localparam logic [PW-1:0] POS_END = PW'(LED_COUNT + 1);

	logic                         busy_q;
	logic [PW-1:0]                pos_q;
	lslm_pkg::task_t              cur_q;
	logic                         out_valid_q;
	logic [lslm_pkg::WORD_W-1:0] out_word_q;
	logic                         out_last_q;
	logic                         adv;
	logic [lslm_pkg::POS_W-1:0]  led;
	logic [lslm_pkg::WORD_W-1:0] led_word;
	logic [lslm_pkg::WORD_W-1:0] next_word;

	assign adv       = !out_valid_q || frame.ready;
	assign pop_ready = adv && !busy_q;

	// led index of the current position (position 1 is led 0; the start word goes out while idle)
	assign led = lslm_pkg::POS_W'(pos_q) - 8'd1;

	always_comb begin
		if (cur_q.hit && lslm_pkg::near(led, cur_q.target, 8'd1)) begin
			led_word = lslm_pkg::WORD_GREEN;
		end else if (lslm_pkg::near(led, cur_q.marker, 8'd1)) begin
			led_word = {lslm_pkg::HDR_FULL, colour.blue, colour.green, colour.red};
		end else if (lslm_pkg::near(led, cur_q.target, 8'd2)) begin
			led_word = lslm_pkg::WORD_GREEN;
		end else begin
			led_word = lslm_pkg::WORD_OFF;
		end
		if (!busy_q) begin
			next_word = lslm_pkg::WORD_START;
		end else if (pos_q == POS_END) begin
			next_word = lslm_pkg::WORD_END;
		end else begin
			next_word = led_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				pos_q       <= pos_q + 1'b1;
				if (pos_q == POS_END) begin
					busy_q <= 1'b0;
				end
			end else if (pop_valid) begin
				out_valid_q <= 1'b1;
				pos_q       <= PW'(1);
				busy_q      <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_q <= pop_data;
		end
		if (adv) begin
			out_word_q <= next_word;
			out_last_q <= busy_q && (pos_q == POS_END);
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_word = out_word_q;
	assign frame.last       = out_last_q;

endmodule

FILE: sv/led_strip_level_marker_frames.sv
// ----------------------------------------------------------------------------
// led_strip_level_marker_frames: level-marker led strip frame generator
// Turns a level and a target position into a full strip frame of 32-bit
// words: start word, LED_COUNT led words, end word.
// ----------------------------------------------------------------------------
// path: front stage register, queue, then the output register with the first word
// throughput: LED_COUNT + 2 words per request, one word per cycle while the receiver
//   is ready; the back sequencer emitting words sets the pace of requests
// up to three requests can be held ahead of the back (front stage plus queue)
// reset: arst_n clears control state at once; colour registers go to red
module led_strip_level_marker_frames #(
	parameter int LED_COUNT = 60
) (
	input  logic                             clk,
	input  logic                             arst_n,
	lslm_req_if.sink                         req,
	lslm_frame_if.source                     frame,
	input  logic                             cfg_we,
	input  logic [lslm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lslm_pkg::CFG_W-1:0]      cfg_data
);

	// classified requests between front and queue
	logic            push_valid;
	logic            push_ready;
	lslm_pkg::task_t push_data;
	// queue to back
	logic            pop_valid;
	logic            pop_ready;
	lslm_pkg::task_t pop_data;
	// marker colour registers
	lslm_pkg::colour_t colour_q;

	// config writes; an index beyond the register list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q.red   <= lslm_pkg::RED_RESET;
			colour_q.green <= lslm_pkg::GREEN_RESET;
			colour_q.blue  <= lslm_pkg::BLUE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lslm_pkg::REG_MARKER_RED:   colour_q.red   <= cfg_data;
				lslm_pkg::REG_MARKER_GREEN: colour_q.green <= cfg_data;
				lslm_pkg::REG_MARKER_BLUE:  colour_q.blue  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: takes the request, works out the marker and the hit flag
	lslm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// short queue so the front keeps taking requests while a frame streams out
	lslm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	// back: sequences the frame words through the output register
	lslm_back #(
		.LED_COUNT (LED_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.colour    (colour_q),
		.frame     (frame)
	);

endmodule

FILE: sv/lslm_checker.sv
// ----------------------------------------------------------------------------
// lslm_checker: port-level checks of the strip framer
// Watches the frame channel for framing and stall behaviour.
// ----------------------------------------------------------------------------
module lslm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [lslm_pkg::WORD_W-1:0] out_word,
	input logic                         out_last
);

	// a stalled word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
		else $error("frame word changed while stalled");

	// the end word is all ones
	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_word == lslm_pkg::WORD_END)
		else $error("end word wrong");

	// every word whose top three bits are not all set is the start word and not last
	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word[31:29] != 3'b111 |-> out_word == lslm_pkg::WORD_START && !out_last)
		else $error("word without led header");

	// a word shown right after an end word opens a new frame
	a_next_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) ##1 out_valid |-> out_word == lslm_pkg::WORD_START)
		else $error("frame did not open with start word");

	// nothing shown straight out of reset
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("word shown out of reset");

endmodule

bind led_strip_level_marker_frames lslm_checker u_lslm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (frame.valid),
	.out_ready (frame.ready),
	.out_word  (frame.frame_word),
	.out_last  (frame.last)
);

FILE: dv/led_strip_level_marker_frames_tb.sv
// ----------------------------------------------------------------------------
// led_strip_level_marker_frames_tb: self-checking bench of the strip framer
// Sends level/target requests over the request channel and compares every
// strip word against a local frame predictor: a directed table of corners,
// then random requests under several marker colour settings, with random
// idling on both channels and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module led_strip_level_marker_frames_tb;

	localparam int LEDS             = 60;
	localparam int WORDS_PER_FRAME  = LEDS + 2;
	localparam int RAND_PER_PHASE   = 46;
	localparam int PHASES           = 5;
	localparam int LONG_HOLD        = 300;
	localparam int HOLD_AFTER_WORDS = WORDS_PER_FRAME * 80;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int END_SETTLE       = 16;
	localparam int MAX_PRINTED      = 100;

	// index that decodes to no register; a write there must change nothing
	localparam logic [lslm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// one expected strip word
	typedef struct {
		logic [lslm_pkg::WORD_W-1:0] word;
		logic                        last;
	} strip_word_t;

	// directed row: dark means the frame is start, all leds off, end
	typedef struct {
		logic [lslm_pkg::LEVEL_W-1:0] level;
		logic [lslm_pkg::POS_W-1:0]   target;
		bit                           dark;
	} corner_row_t;

	localparam int N_CORNERS = 22;

	corner_row_t corner_rows [N_CORNERS] = '{
		'{8'd0,   8'd255, 1'b1},	// marker wraps to 248, target far off the strip
		'{8'd23,  8'd128, 1'b1},	// highest level that still wraps, marker 255
		'{8'd255, 8'd200, 1'b1},	// top level, marker 77 beyond the strip
		'{8'd210, 8'd100, 1'b1},	// marker 62, its neighbours just off the strip
		'{8'd24,  8'd30,  1'b0},	// lowest level without wrap, marker on led 0
		'{8'd27,  8'd0,   1'b0},	// marker 1 hits target 0 at the strip start
		'{8'd26,  8'd1,   1'b0},	// marker 0 hits target 1
		'{8'd255, 8'd0,   1'b0},	// target 0 with no neighbour below
		'{8'd84,  8'd20,  1'b0},	// marker on the target
		'{8'd87,  8'd20,  1'b0},	// marker one above the target
		'{8'd90,  8'd20,  1'b0},	// marker two above: colour wins over the outer ring
		'{8'd81,  8'd20,  1'b0},	// marker one below the target
		'{8'd78,  8'd20,  1'b0},	// marker two below
		'{8'd201, 8'd59,  1'b0},	// marker and target on the last led
		'{8'd204, 8'd40,  1'b0},	// marker 60 lights only led 59
		'{8'd207, 8'd10,  1'b0},	// marker 61 reaches nothing
		'{8'd100, 8'd60,  1'b0},	// target just past the end
		'{8'd100, 8'd61,  1'b0},
		'{8'd100, 8'd62,  1'b0},	// only the outer ring could reach, and does not
		'{8'd150, 8'd57,  1'b0},
		'{8'd198, 8'd57,  1'b0},	// marker 58 hits target 57 near the end
		'{8'd24,  8'd255, 1'b0}		// marker 0 with the target far away
	};

	logic clk;
	logic arst_n;
	logic                           cfg_we;
	logic [lslm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lslm_pkg::CFG_W-1:0]     cfg_data;

	lslm_req_if   req_ch ();
	lslm_frame_if frame_ch ();

	led_strip_level_marker_frames #(
		.LED_COUNT (LEDS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.frame     (frame_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local copy of the marker colour registers
	lslm_pkg::colour_t marker_colour;

	strip_word_t expected_words [$];

	int  mismatches;
	int  words_seen;
	int  requests_sent;
	int  colour_settings;
	int  quiet_cycles;
	bit  no_gaps;
	bit  long_hold_done;

	// clock: period 4
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ---------------------------------------------------------------------
	// frame predictor
	// ---------------------------------------------------------------------

	// plain distance, no wrap-around at either end of the strip
	function automatic int span(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [lslm_pkg::WORD_W-1:0] led_word(input int led, input int mk,
			input int tg, input bit hit);
		if (hit && span(led, tg) <= 1) begin
			return lslm_pkg::WORD_GREEN;
		end else if (span(led, mk) <= 1) begin
			return {lslm_pkg::HDR_FULL, marker_colour};
		end else if (span(led, tg) <= 2) begin
			return lslm_pkg::WORD_GREEN;
		end
		return lslm_pkg::WORD_OFF;
	endfunction

	task automatic predict_frame(input logic [lslm_pkg::LEVEL_W-1:0] level,
			input logic [lslm_pkg::POS_W-1:0] target);
		logic [lslm_pkg::POS_W-1:0] mk;
		bit                         hit;
		// marker = level div 3 minus 8, kept to 8 bits so low levels wrap high
		mk  = level / 8'd3;
		mk  = mk - 8'd8;
		hit = span(int'(mk), int'(target)) <= 1;
		expected_words.push_back('{lslm_pkg::WORD_START, 1'b0});
		for (int led = 0; led < LEDS; led++) begin
			expected_words.push_back('{led_word(led, int'(mk), int'(target), hit), 1'b0});
		end
		expected_words.push_back('{lslm_pkg::WORD_END, 1'b1});
	endtask

	// typed-in frame for corners where nothing lands on the strip
	task automatic push_dark_frame();
		expected_words.push_back('{32'h0000_0000, 1'b0});
		for (int led = 0; led < LEDS; led++) begin
			expected_words.push_back('{32'hE000_0000, 1'b0});
		end
		expected_words.push_back('{32'hFFFF_FFFF, 1'b1});
	endtask

	// ---------------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [lslm_pkg::WORD_W-1:0] got,
			input logic [lslm_pkg::WORD_W-1:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("mismatch: %0s at strip word %0d: got %h, expected %h",
				what, words_seen, got, want);
		end
	endtask

	// every word taken by the receiver is checked against the oldest expectation
	always @(posedge clk) begin
		strip_word_t want;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", frame_ch.frame_word, '0);
			end else begin
				want = expected_words.pop_front();
				if (frame_ch.frame_word !== want.word) begin
					report_mismatch("frame_word", frame_ch.frame_word, want.word);
				end
				if (frame_ch.last !== want.last) begin
					report_mismatch("last", {31'd0, frame_ch.last}, {31'd0, want.last});
				end
			end
			words_seen++;
		end
	end

	// watchdog: too long without any handshake on either channel ends the run
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (frame_ch.valid && frame_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d words outstanding",
					WATCHDOG_LIMIT, expected_words.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// idling
	// ---------------------------------------------------------------------

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// receiver: random ready gaps, plus one long hold-off so the block backs up
	initial begin
		int gap;
		frame_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!long_hold_done && words_seen >= HOLD_AFTER_WORDS) begin
				frame_ch.ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_done = 1'b1;
			end
			gap = pick_gap();
			if (gap > 0) begin
				frame_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			frame_ch.ready = 1'b1;
			@(negedge clk);
		end
	end

	// ---------------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------------

	// called at a falling edge; returns at a falling edge with valid still high
	task automatic send_request(input logic [lslm_pkg::LEVEL_W-1:0] level,
			input logic [lslm_pkg::POS_W-1:0] target, input bit dark);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid  = 1'b1;
		req_ch.level  = level;
		req_ch.target = target;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (dark) begin
			push_dark_frame();
		end else begin
			predict_frame(level, target);
		end
		requests_sent++;
		@(negedge clk);
	endtask

	// random request: often a marker placed around a target on or just past the strip
	task automatic send_random();
		int unsigned                  pick;
		int                           mk;
		logic [lslm_pkg::LEVEL_W-1:0] level;
		logic [lslm_pkg::POS_W-1:0]   target;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			target = lslm_pkg::POS_W'($urandom_range(0, LEDS + 3));
			mk     = int'(target) + int'($urandom_range(0, 6)) - 3;
			if (mk < 0) begin
				mk = 0;
			end
			level = lslm_pkg::LEVEL_W'(3 * (mk + 8) + int'($urandom_range(0, 2)));
		end else if (pick < 75) begin
			target = lslm_pkg::POS_W'($urandom_range(0, LEDS + 3));
			level  = lslm_pkg::LEVEL_W'($urandom);
		end else begin
			target = lslm_pkg::POS_W'($urandom);
			level  = lslm_pkg::LEVEL_W'($urandom);
		end
		send_request(level, target, 1'b0);
	endtask

	// lower valid and wait for the last expected word; the block is idle then
	task automatic wait_frames_done();
		req_ch.valid = 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [lslm_pkg::CFG_IDX_W-1:0] index,
			input logic [lslm_pkg::CFG_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = index;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (index)
			lslm_pkg::REG_MARKER_RED:   marker_colour.red   = data;
			lslm_pkg::REG_MARKER_GREEN: marker_colour.green = data;
			lslm_pkg::REG_MARKER_BLUE:  marker_colour.blue  = data;
			default: ;	// unused index, ignored by the block
		endcase
	endtask

	task automatic set_colour(input logic [lslm_pkg::CFG_W-1:0] red,
			input logic [lslm_pkg::CFG_W-1:0] green, input logic [lslm_pkg::CFG_W-1:0] blue);
		write_reg(lslm_pkg::REG_MARKER_RED, red);
		write_reg(lslm_pkg::REG_MARKER_GREEN, green);
		write_reg(lslm_pkg::REG_MARKER_BLUE, blue);
		colour_settings++;
	endtask

	// ---------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = lslm_pkg::REG_MARKER_RED;
		cfg_data        = '0;
		req_ch.valid    = 1'b0;
		req_ch.level    = '0;
		req_ch.target   = '0;
		mismatches      = 0;
		words_seen      = 0;
		requests_sent   = 0;
		colour_settings = 1;
		no_gaps         = 1'b0;
		long_hold_done  = 1'b0;
		marker_colour   = '{blue: lslm_pkg::BLUE_RESET, green: lslm_pkg::GREEN_RESET,
			red: lslm_pkg::RED_RESET};

		// hold reset, then release it away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corner table under the reset colour (red marker)
		for (int i = 0; i < N_CORNERS; i++) begin
			send_request(corner_rows[i].level, corner_rows[i].target, corner_rows[i].dark);
		end

		// random phases, each under its own colour; the sender stops and lets
		// every frame drain before the registers change
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_frames_done();
			case (phase)
				0: set_colour(8'h00, 8'h00, 8'h00);
				1: set_colour(8'hFF, 8'hFF, 8'hFF);
				default: set_colour(lslm_pkg::CFG_W'($urandom), lslm_pkg::CFG_W'($urandom),
					lslm_pkg::CFG_W'($urandom));
			endcase
			// a write to the spare index must leave the colour alone
			if (phase == 3) begin
				write_reg(REG_UNUSED, lslm_pkg::CFG_W'($urandom));
			end
			// phase 1 runs flat out on both sides; the long receiver hold falls in it
			no_gaps = (phase == 1);
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				send_random();
			end
		end
		no_gaps = 1'b0;

		// drain, then give the block time to show any stray word
		wait_frames_done();
		repeat (END_SETTLE) @(posedge clk);

		$display("covered %0d requests (%0d table corners) under %0d marker colours",
			requests_sent, N_CORNERS, colour_settings);
		$display("checked %0d strip words, long back-pressure hold %0s",
			words_seen, long_hold_done ? "seen" : "not reached");
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
